FILE: rtl/perceptron_branch_predictor_defines.svh
// Assertion macros shared by the perceptron predictor RTL.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PBP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pbp_pkg.sv
// Shared types and constants of the perceptron branch predictor.
package pbp_pkg;

    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int HLEN_W     = 5;
    localparam int COUNT_W    = 9;
    localparam int THRESH_W   = 12;
    localparam int SUM_OUT_W  = 13;
    localparam int LANES      = 8;
    localparam int LOG_LANES  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERCEPTRON_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAINING_THRESHOLD = 2'd2;

    localparam logic [HLEN_W-1:0]   HLEN_RESET   = 5'd16;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd256;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd32;

    // History entry codes: +1, -1, empty
    localparam logic [1:0] HIST_TAKEN     = 2'b01;
    localparam logic [1:0] HIST_NOT_TAKEN = 2'b11;
    localparam logic [1:0] HIST_EMPTY     = 2'b00;

    typedef struct packed {
        logic clear;   // write a zero row at the sweep address
        logic load;    // latch the word, read its row
        logic accum;   // add one chunk of terms
        logic finish;  // report, train, shift history
    } pbp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic chunk_last;
        logic item_invalid;
    } pbp_sts_t;

endpackage

FILE: rtl/perceptron_branch_predictor.sv
// Flow: start is taken while idle as load, which reads the row; the sum loop then adds eight weight
//   terms a cycle over the used history, then finish trains, shifts history and registers the
//   result, which is strobed on done. An invalid index skips the sum loop and goes straight to
//   finish. A new word is taken only once the last one has finished.
// Reset: configuration returns to 16/256/32 and history empties, then a sweep zeroes the
//   weight memory one row a cycle; busy stays high until it ends.
module perceptron_branch_predictor #(
    parameter int ENTRIES     = 256,
    parameter int HISTORY_MAX = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [pbp_pkg::INDEX_W-1:0]          branch_index,
    input  logic                                 outcome_taken,
    output logic                                 done,
    output logic                                 predicted_taken,
    output logic signed [pbp_pkg::SUM_OUT_W-1:0] perceptron_sum,
    output logic                                 index_invalid,
    input  logic                                 cfg_write,
    input  logic [pbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pbp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pbp_pkg::*;

    pbp_cmd_t cmd;
    pbp_sts_t sts;

    // Sequencer: sweep the memory after reset, then take one word at a time,
    // hold a valid one through the chunked sum, and finish with train and history shift.
    // Results are strobed for one cycle on done and cannot be held off.
    pbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Datapath: row-wide weight memory read at accept, eight-lane adder per
    // cycle, parallel saturating update written back in the finish cycle.
    pbp_datapath #(
        .ENTRIES     (ENTRIES),
        .HISTORY_MAX (HISTORY_MAX),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .branch_index    (branch_index),
        .outcome_taken   (outcome_taken),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .predicted_taken (predicted_taken),
        .perceptron_sum  (perceptron_sum),
        .index_invalid   (index_invalid)
    );

endmodule

FILE: rtl/pbp_ctrl.sv
// Sequencer of the perceptron predictor: clear sweep, sum loop, finish.
`include "perceptron_branch_predictor_defines.svh"

module pbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pbp_pkg::pbp_sts_t sts,
    output logic              busy,
    output pbp_pkg::pbp_cmd_t cmd
);
    import pbp_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SUM    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.item_invalid ? ST_FINISH : ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.accum = 1'b1;
                if (sts.chunk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `PBP_ASSERT_IMPLY(a_cmd_onehot0, 1'b1, $onehot0(cmd), "more than one command at once")
    `PBP_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_reg == ST_SUM || state_reg == ST_FINISH, "load did not start work")
    `PBP_ASSERT_NEXT(a_finish_frees, cmd.finish, !busy, "still busy after finish")

endmodule

FILE: rtl/pbp_datapath.sv
// Weight memory, history, summing lanes and training logic of the predictor.
`include "perceptron_branch_predictor_defines.svh"

module pbp_datapath #(
    parameter int ENTRIES     = 256,
    parameter int HISTORY_MAX = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pbp_pkg::pbp_cmd_t                      cmd,
    output pbp_pkg::pbp_sts_t                      sts,
    input  logic [pbp_pkg::INDEX_W-1:0]            branch_index,
    input  logic                                   outcome_taken,
    input  logic                                   cfg_write,
    input  logic [pbp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pbp_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                   done,
    output logic                                   predicted_taken,
    output logic signed [pbp_pkg::SUM_OUT_W-1:0]   perceptron_sum,
    output logic                                   index_invalid
);
    import pbp_pkg::*;

    localparam int ROW_LEN  = HISTORY_MAX + 1;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEN_W    = $clog2(HISTORY_MAX + 1);
    localparam int NCHUNK   = (ROW_LEN + LANES - 1) / LANES;
    localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int TERM_W   = WEIGHT_BITS + 1;
    localparam int CSUM_W   = TERM_W + LOG_LANES;
    localparam int SUM_RAW  = WEIGHT_BITS + LOG_LANES + 1 + $clog2(ROW_LEN);
    localparam int SUM_W    = (SUM_RAW > SUM_OUT_W) ? SUM_RAW : SUM_OUT_W;

    localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_t;

    // configuration
    logic [HLEN_W-1:0]   hlen_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // word in flight
    logic [ADDR_W-1:0]   addr_reg;
    logic                outcome_reg;
    logic                inv_reg;
    row_t                row_q;
    logic [CHUNK_W-1:0]  chunk_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [1:0]          hist_reg [HISTORY_MAX];

    // result
    logic                done_reg;
    logic                pred_reg;
    logic signed [SUM_OUT_W-1:0] sum_out_reg;
    logic                inv_out_reg;

    row_t                mem [ENTRIES];

    logic [LEN_W-1:0]    len;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    row_t                wr_data;
    row_t                new_row;
    logic signed [TERM_W-1:0] terms [NCHUNK][LANES];
    logic signed [CSUM_W-1:0] csum;
    logic                acc_neg;
    logic [SUM_W-1:0]    mag;
    logic                train;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlen_reg   <= HLEN_RESET;
            count_reg  <= COUNT_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HISTORY_LENGTH:     hlen_reg   <= cfg_data[HLEN_W-1:0];
                REG_PERCEPTRON_COUNT:   count_reg  <= cfg_data[COUNT_W-1:0];
                REG_TRAINING_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(hlen_reg) >= HISTORY_MAX)
        begin
            len = LEN_W'(HISTORY_MAX);
        end
        else
        begin
            len = LEN_W'(hlen_reg);
        end
    end

    assign rd_addr = ADDR_W'(branch_index);

    assign sts.item_invalid = ({1'b0, branch_index} >= count_reg)
                            || (int'(branch_index) >= ENTRIES);
    assign sts.clear_last   = (clr_addr_reg == ADDR_W'(ENTRIES - 1));
    assign sts.chunk_last   = (int'(chunk_reg) == (int'(len) >> LOG_LANES));

    // weight memory: one row port each way, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // per-weight terms, grouped into chunks of eight lanes
    for (genvar c = 0; c < NCHUNK; c++)
    begin : g_chunk
        for (genvar j = 0; j < LANES; j++)
        begin : g_lane
            localparam int K = c * LANES + j;
            if (K == 0)
            begin : g_bias
                assign terms[c][j] = TERM_W'($signed(row_q[0]));
            end
            else if (K < ROW_LEN)
            begin : g_weight
                logic signed [TERM_W-1:0] w_ext;
                assign w_ext = TERM_W'($signed(row_q[K]));
                assign terms[c][j] = (int'(len) < K)                ? '0 :
                                     (hist_reg[K-1] == HIST_TAKEN)     ? w_ext :
                                     (hist_reg[K-1] == HIST_NOT_TAKEN) ? -w_ext : '0;
            end
            else
            begin : g_pad
                assign terms[c][j] = '0;
            end
        end
    end

    always_comb
    begin
        csum = '0;
        for (int j = 0; j < LANES; j++)
        begin
            csum = csum + CSUM_W'(terms[chunk_reg][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg    <= rd_addr;
            outcome_reg <= outcome_taken;
            inv_reg     <= sts.item_invalid;
            acc_reg     <= '0;
            chunk_reg   <= '0;
        end
        else if (cmd.accum)
        begin
            acc_reg   <= acc_reg + SUM_W'(csum);
            chunk_reg <= chunk_reg + CHUNK_W'(1);
        end
    end

    // training decision
    assign acc_neg = acc_reg[SUM_W-1];
    assign mag     = acc_neg ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign train   = (acc_neg == outcome_reg) || (mag <= SUM_W'(thresh_reg));

    // saturating step of each weight by outcome times history entry
    for (genvar k = 0; k < ROW_LEN; k++)
    begin : g_upd
        logic inc;
        logic dec;
        if (k == 0)
        begin : g_bias
            assign inc = outcome_reg;
            assign dec = !outcome_reg;
        end
        else
        begin : g_weight
            logic used;
            assign used = (int'(len) >= k);
            assign inc  = used && ((hist_reg[k-1] == HIST_TAKEN && outcome_reg)
                               || (hist_reg[k-1] == HIST_NOT_TAKEN && !outcome_reg));
            assign dec  = used && ((hist_reg[k-1] == HIST_TAKEN && !outcome_reg)
                               || (hist_reg[k-1] == HIST_NOT_TAKEN && outcome_reg));
        end
        assign new_row[k] = (inc && row_q[k] != W_MAX) ? row_q[k] + WEIGHT_BITS'(1) :
                            (dec && row_q[k] != W_MIN) ? row_q[k] - WEIGHT_BITS'(1) :
                            row_q[k];
    end

    assign wr_en   = cmd.clear || (cmd.finish && !inv_reg && train);
    assign wr_addr = cmd.clear ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clear ? '0 : new_row;

    // shift the outcome into the global history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_MAX; i++)
            begin
                hist_reg[i] <= HIST_EMPTY;
            end
        end
        else if (cmd.finish && !inv_reg)
        begin
            for (int i = 0; i < HISTORY_MAX; i++)
            begin
                if (i == 0)
                begin
                    hist_reg[0] <= outcome_reg ? HIST_TAKEN : HIST_NOT_TAKEN;
                end
                else if (i < int'(len))
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            pred_reg    <= !inv_reg && !acc_neg;
            sum_out_reg <= inv_reg ? '0 : acc_reg[SUM_OUT_W-1:0];
            inv_out_reg <= inv_reg;
        end
    end

    assign done            = done_reg;
    assign predicted_taken = pred_reg;
    assign perceptron_sum  = sum_out_reg;
    assign index_invalid   = inv_out_reg;

    `PBP_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held two cycles")
    `PBP_ASSERT_IMPLY(a_no_result_in_sweep, cmd.clear, !done_reg, "result during clear sweep")

endmodule
